// ===== hw/rtl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

  localparam int ROM_ADDR_W = 21;
  localparam int RAM_ADDR_W = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 21;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_SIZE_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_SIZE_MASK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_PRESENT   = 2'd2;

  // Mapper register selects, address bits 14 and 13.
  localparam logic [1:0] SEL_RAM_ENABLE = 2'd0;
  localparam logic [1:0] SEL_ROM_BANK   = 2'd1;
  localparam logic [1:0] SEL_RAM_BANK   = 2'd2;
  localparam logic [1:0] SEL_MODEL      = 2'd3;

  localparam logic [7:0] RAM_ENABLE_KEY = 8'h0a;

  localparam logic [ROM_ADDR_W-1:0] RESET_ROM_SIZE_MASK = 21'h007fff;
  localparam logic [RAM_ADDR_W-1:0] RESET_RAM_SIZE_MASK = 15'h1fff;
  localparam logic [ROM_ADDR_W-1:0] BANK_ONE_BASE       = 21'h004000;
  localparam logic [ROM_ADDR_W-1:0] RESET_ROM_BASE      = BANK_ONE_BASE & RESET_ROM_SIZE_MASK;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data;
  } cpu_write_t;

  typedef struct packed {
    logic [ROM_ADDR_W-1:0] rom_window_base;
    logic                  ram_write_grant;
    logic [RAM_ADDR_W-1:0] ram_write_address;
    logic [7:0]            ram_write_data;
  } map_result_t;

  typedef struct packed {
    logic [ROM_ADDR_W-1:0] rom_size_mask;
    logic [RAM_ADDR_W-1:0] ram_size_mask;
    logic                  ram_present;
  } cbm_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: request pipeline and configuration registers.
//
//   channel   direction  handshake             payload
//   cpu       in         cpu_valid/cpu_stall   cpu_write (address, data)
//   map       out        map_valid/map_stall   map_result (rom base, RAM write)
//   cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A request is registered on acceptance and its result is registered in map_result
// when it advances, so one request can be taken every cycle while map does not stall.
// The input register and the result register form a two-entry pipeline; a stall
// on map backs up into cpu_stall in the same cycle. Synchronous reset clears the
// valid flags, the mapper registers and the configuration to their reset values.
`default_nettype none

module cartridge_bank_mapper (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cpu_valid,
  output logic                             cpu_stall,
  input  wire cbm_pkg::cpu_write_t         cpu_write,
  output logic                             map_valid,
  input  wire                              map_stall,
  output cbm_pkg::map_result_t             map_result,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [cbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [cbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cbm_pkg::*;

  cbm_cfg_t    cfg;
  cpu_write_t  req;
  logic        req_valid;
  logic        advance;
  map_result_t result;

  assign advance   = req_valid & (~map_valid | ~map_stall);
  assign cpu_stall = req_valid & ~advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_size_mask <= RESET_ROM_SIZE_MASK;
      cfg.ram_size_mask <= RESET_RAM_SIZE_MASK;
      cfg.ram_present   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROM_SIZE_MASK: cfg.rom_size_mask <= cfg_data[ROM_ADDR_W-1:0];
        CFG_RAM_SIZE_MASK: cfg.ram_size_mask <= cfg_data[RAM_ADDR_W-1:0];
        CFG_RAM_PRESENT:   cfg.ram_present   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      map_valid <= 1'b0;
    end else begin
      if (cpu_valid && !cpu_stall) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        map_valid <= 1'b1;
      end else if (!map_stall) begin
        map_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cpu_valid && !cpu_stall) begin
      req <= cpu_write;
    end
    if (advance) begin
      map_result <= result;
    end
  end

  cbm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cpu_write (req),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cbm_core.sv =====
// Mapper register file and the address mapping for one CPU write.
`default_nettype none

module cbm_core (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       advance,
  input  wire cbm_pkg::cpu_write_t  cpu_write,
  input  wire cbm_pkg::cbm_cfg_t    cfg,
  output cbm_pkg::map_result_t      result
);
  import cbm_pkg::*;

  logic                  ram_enabled, ram_enabled_next;
  logic [5:0]            rom_bank, rom_bank_next;
  logic [1:0]            ram_bank, ram_bank_next;
  logic                  memory_model, memory_model_next;
  logic [1:0]            rom_high_bits, rom_high_bits_next;
  logic [RAM_ADDR_W-1:0] ram_base, ram_base_next;
  logic [ROM_ADDR_W-1:0] rom_base, rom_base_next;

  logic [5:0] bank_sel;
  logic       is_reg;
  logic       is_ram;

  assign is_reg = ~cpu_write.address[15];
  assign is_ram = (cpu_write.address[15:13] == 3'b101);
  assign bank_sel = (cpu_write.data[5:0] == 6'd0) ? 6'd1 : cpu_write.data[5:0];

  always_comb begin
    ram_enabled_next   = ram_enabled;
    rom_bank_next      = rom_bank;
    ram_bank_next      = ram_bank;
    memory_model_next  = memory_model;
    rom_high_bits_next = rom_high_bits;
    ram_base_next      = ram_base;
    rom_base_next      = rom_base;
    if (is_reg) begin
      unique case (cpu_write.address[14:13])
        SEL_RAM_ENABLE: begin
          ram_enabled_next = ((cpu_write.data & RAM_ENABLE_KEY) == RAM_ENABLE_KEY);
        end
        SEL_ROM_BANK: begin
          // The high bits stay stored but are not part of this base.
          if (bank_sel != rom_bank) begin
            rom_bank_next = bank_sel;
            rom_base_next = {1'b0, bank_sel, 14'd0} & cfg.rom_size_mask;
          end
        end
        SEL_RAM_BANK: begin
          if (memory_model) begin
            if (cpu_write.data[1:0] != ram_bank) begin
              ram_bank_next = cpu_write.data[1:0];
              ram_base_next = {cpu_write.data[1:0], 13'd0} & cfg.ram_size_mask;
            end
          end else begin
            rom_high_bits_next = cpu_write.data[1:0];
            rom_base_next = ({1'b0, rom_bank, 14'd0} | {cpu_write.data[1:0], 19'd0})
                            & cfg.rom_size_mask;
          end
        end
        SEL_MODEL: begin
          memory_model_next = cpu_write.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.rom_window_base   = rom_base_next;
    result.ram_write_grant   = 1'b0;
    result.ram_write_address = '0;
    result.ram_write_data    = '0;
    if (is_ram && ram_enabled && cfg.ram_present) begin
      result.ram_write_grant   = 1'b1;
      result.ram_write_address = ram_base + {2'b00, cpu_write.address[12:0]};
      result.ram_write_data    = cpu_write.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled   <= 1'b0;
      rom_bank      <= 6'd1;
      ram_bank      <= 2'd0;
      memory_model  <= 1'b0;
      rom_high_bits <= 2'd0;
      ram_base      <= '0;
      rom_base      <= RESET_ROM_BASE;
    end else if (advance) begin
      ram_enabled   <= ram_enabled_next;
      rom_bank      <= rom_bank_next;
      ram_bank      <= ram_bank_next;
      memory_model  <= memory_model_next;
      rom_high_bits <= rom_high_bits_next;
      ram_base      <= ram_base_next;
      rom_base      <= rom_base_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/cartridge_bank_mapper_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cartridge bank mapper with a built-in mapper predictor.

module cartridge_bank_mapper_test;
  import cbm_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int PIPE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;
  localparam int SLOT_ITEMS = 122;
  // Address bits 15:13 of the external RAM window at 0xA000-0xBFFF.
  localparam logic [2:0] RAM_WINDOW = 3'b101;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cpu_valid = 1'b0;
  logic cpu_stall;
  cpu_write_t cpu_write = '0;
  logic map_valid;
  logic map_stall = 1'b0;
  map_result_t map_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ROM_SIZE_MASK;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted mapper state and configuration.
  logic [ROM_ADDR_W-1:0] rom_mask_now;
  logic [RAM_ADDR_W-1:0] ram_mask_now;
  logic ram_fitted;
  logic ram_on;
  logic [5:0] cur_rom_bank;
  logic [1:0] cur_ram_bank;
  logic model_sel;
  logic [1:0] rom_hi;
  logic [RAM_ADDR_W-1:0] ram_bank_base;
  logic [ROM_ADDR_W-1:0] rom_window;

  map_result_t pending_maps[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  cartridge_bank_mapper dut (
    .clk(clk),
    .rst(rst),
    .cpu_valid(cpu_valid),
    .cpu_stall(cpu_stall),
    .cpu_write(cpu_write),
    .map_valid(map_valid),
    .map_stall(map_stall),
    .map_result(map_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic reset_mapper_state();
    rom_mask_now = RESET_ROM_SIZE_MASK;
    ram_mask_now = RESET_RAM_SIZE_MASK;
    ram_fitted = 1'b1;
    ram_on = 1'b0;
    cur_rom_bank = 6'd1;
    cur_ram_bank = 2'd0;
    model_sel = 1'b0;
    rom_hi = 2'd0;
    ram_bank_base = '0;
    rom_window = BANK_ONE_BASE & RESET_ROM_SIZE_MASK;
  endtask

  // Applies one CPU write to the predicted state and returns the expected result.
  function automatic map_result_t map_cpu_write(input cpu_write_t w);
    map_result_t r;
    logic [5:0] bank;
    logic [1:0] rbank;
    r = '0;
    if (!w.address[15]) begin
      case (w.address[14:13])
        SEL_RAM_ENABLE: begin
          ram_on = ((w.data & RAM_ENABLE_KEY) == RAM_ENABLE_KEY);
        end
        SEL_ROM_BANK: begin
          bank = w.data[5:0];
          if (bank == 6'd0) bank = 6'd1;
          if (bank != cur_rom_bank) begin
            cur_rom_bank = bank;
            // The stored high bits are not part of the new base.
            rom_window = {1'b0, bank, 14'd0} & rom_mask_now;
          end
        end
        SEL_RAM_BANK: begin
          if (model_sel) begin
            rbank = w.data[1:0];
            if (rbank != cur_ram_bank) begin
              cur_ram_bank = rbank;
              ram_bank_base = {rbank, 13'd0} & ram_mask_now;
            end
          end else begin
            rom_hi = w.data[1:0];
            rom_window = ({1'b0, cur_rom_bank, 14'd0} | {rom_hi, 19'd0}) & rom_mask_now;
          end
        end
        default: begin
          model_sel = w.data[0];
        end
      endcase
    end else if (w.address[15:13] == RAM_WINDOW && ram_on && ram_fitted) begin
      r.ram_write_grant = 1'b1;
      r.ram_write_address = ram_bank_base + {2'b00, w.address[12:0]};
      r.ram_write_data = w.data;
    end
    r.rom_window_base = rom_window;
    return r;
  endfunction

  task automatic send_write(input logic [15:0] address, input logic [7:0] data);
    cpu_write_t w;
    w.address = address;
    w.data = data;
    while ($urandom_range(99) < send_idle_pct) begin
      cpu_valid <= 1'b0;
      @(posedge clk);
    end
    cpu_valid <= 1'b1;
    cpu_write <= w;
    @(posedge clk);
    while (cpu_stall) @(posedge clk);
    pending_maps.push_back(map_cpu_write(w));
  endtask

  // Holds off new requests until every expected result has come back.
  task automatic drain_maps();
    cpu_valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg_reg(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_ROM_SIZE_MASK: rom_mask_now = value[ROM_ADDR_W-1:0];
      CFG_RAM_SIZE_MASK: ram_mask_now = value[RAM_ADDR_W-1:0];
      CFG_RAM_PRESENT:   ram_fitted = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input cbm_cfg_t c);
    drain_maps();
    write_cfg_reg(CFG_ROM_SIZE_MASK, CFG_DATA_W'(c.rom_size_mask));
    write_cfg_reg(CFG_RAM_SIZE_MASK, CFG_DATA_W'(c.ram_size_mask));
    write_cfg_reg(CFG_RAM_PRESENT, CFG_DATA_W'(c.ram_present));
    cfg_valid <= 1'b0;
  endtask

  function automatic cbm_cfg_t pick_config(input int slot);
    cbm_cfg_t c;
    case (slot % 4)
      0: c = '{rom_size_mask: '1, ram_size_mask: '1, ram_present: 1'b1};
      1: c = '{rom_size_mask: '0, ram_size_mask: '0, ram_present: 1'b1};
      2: c = '{rom_size_mask: ROM_ADDR_W'((1 << $urandom_range(21, 14)) - 1),
               ram_size_mask: RAM_ADDR_W'((1 << $urandom_range(15, 13)) - 1),
               ram_present: 1'b1};
      default: c = '{rom_size_mask: ROM_ADDR_W'($urandom),
                     ram_size_mask: RAM_ADDR_W'($urandom),
                     ram_present: 1'($urandom)};
    endcase
    return c;
  endfunction

  // Mostly register and RAM window writes, with the rest anywhere in the map.
  function automatic cpu_write_t random_cpu_write();
    cpu_write_t w;
    int pick;
    pick = $urandom_range(99);
    w.address = 16'($urandom);
    w.data = 8'($urandom);
    if (pick < 14) begin
      w.address[15:13] = {1'b0, SEL_RAM_ENABLE};
      if (pick < 9) w.data = w.data | RAM_ENABLE_KEY;
    end else if (pick < 34) begin
      w.address[15:13] = {1'b0, SEL_ROM_BANK};
      if (pick < 20) w.data[5:0] = 6'($urandom_range(2));
    end else if (pick < 48) begin
      w.address[15:13] = {1'b0, SEL_RAM_BANK};
    end else if (pick < 56) begin
      w.address[15:13] = {1'b0, SEL_MODEL};
    end else if (pick < 88) begin
      w.address[15:13] = RAM_WINDOW;
    end
    return w;
  endfunction

  task automatic test_reset_state();
    send_write(16'h8000, 8'h55);
    send_write(16'hA000, 8'h12);
    send_write(16'hFFFF, 8'hFF);
  endtask

  task automatic test_ram_enable();
    send_write(16'h0000, 8'h0A);
    send_write(16'hB000, 8'hA5);
    send_write(16'h1FFF, 8'h08);
    send_write(16'hA001, 8'h3C);
    send_write(16'h0100, 8'hFF);
    send_write(16'hBFFF, 8'h00);
  endtask

  task automatic test_rom_bank();
    send_write(16'h2000, 8'h00);
    send_write(16'h3FFF, 8'h3F);
    send_write(16'h2000, 8'hFF);
    send_write(16'h2100, 8'h40);
  endtask

  task automatic test_bank_registers();
    send_write(16'h4000, 8'h03);
    send_write(16'h6000, 8'h01);
    send_write(16'h5FFF, 8'h03);
    send_write(16'h4000, 8'hFF);
    send_write(16'hBFFF, 8'h77);
    send_write(16'h7FFF, 8'hFE);
    send_write(16'h4000, 8'h00);
    send_write(16'h9FFF, 8'hAA);
    send_write(16'hC000, 8'h11);
  endtask

  task automatic test_ram_absent();
    set_config('{rom_size_mask: '1, ram_size_mask: '1, ram_present: 1'b0});
    send_write(16'hA000, 8'h5A);
  endtask

  task automatic test_random_traffic(input int first_slot);
    cpu_write_t w;
    for (int slot = first_slot; slot < first_slot + 3; slot++) begin
      set_config(pick_config(slot));
      for (int n = 0; n < SLOT_ITEMS; n++) begin
        if (n == SLOT_ITEMS / 2) drain_maps();
        w = random_cpu_write();
        send_write(w.address, w.data);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    map_result_t want;
    if (rst) begin
      map_stall <= 1'b0;
    end else begin
      if (map_valid && !map_stall) begin
        if (pending_maps.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = pending_maps.pop_front();
          if (map_result.rom_window_base !== want.rom_window_base)
            report_mismatch($sformatf("rom_window_base %h, expected %h",
                                      map_result.rom_window_base, want.rom_window_base));
          if (map_result.ram_write_grant !== want.ram_write_grant)
            report_mismatch($sformatf("ram_write_grant %b, expected %b",
                                      map_result.ram_write_grant, want.ram_write_grant));
          if (map_result.ram_write_address !== want.ram_write_address)
            report_mismatch($sformatf("ram_write_address %h, expected %h",
                                      map_result.ram_write_address, want.ram_write_address));
          if (map_result.ram_write_data !== want.ram_write_data)
            report_mismatch($sformatf("ram_write_data %h, expected %h",
                                      map_result.ram_write_data, want.ram_write_data));
        end
      end
      map_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Ends the run if no channel makes progress for too long.
  always @(posedge clk) begin
    if ((cpu_valid && !cpu_stall) || (map_valid && !map_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 82;
    reset_mapper_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    set_config('{rom_size_mask: '1, ram_size_mask: '1, ram_present: 1'b1});
    test_ram_enable();
    test_rom_bank();
    test_bank_registers();
    test_ram_absent();

    test_random_traffic(0);
    send_idle_pct = 82;
    recv_idle_pct = 16;
    test_random_traffic(3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(6);

    drain_maps();
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
